>>> design/kci_pkg.sv
// shared constants, codes and types of the keyframe color interpolator
package kci_pkg;

  localparam int BANDS_DEF = 18;
  localparam int KEYS_DEF  = 16;
  localparam int DAY_TICKS = 2880;

  localparam int OPCODE_W = 2;
  localparam int BAND_W   = 5;
  localparam int SLOT_W   = 4;
  localparam int TIME_W   = 12;
  localparam int COLOR_W  = 24;
  localparam int COUNT_W  = 5;
  localparam int CHAN_W   = 8;

  // times after the day wrap reach 4095 + 2880, differences need a sign
  localparam int XTIME_W = 13;
  localparam int DIFF_W  = 14;
  localparam int SPAN_W  = 13;
  localparam int NUM_W   = 21;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE_KEY = 2'd0,
    OP_SET_COUNT = 2'd1,
    OP_QUERY     = 2'd2
  } opcode_e;

  typedef struct packed {
    logic [TIME_W-1:0]  ktime;
    logic [COLOR_W-1:0] color;
  } key_entry_t;

endpackage

>>> design/kci_in_if.sv
// input channel: write, count and query items
interface kci_in_if import kci_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [BAND_W-1:0]   band;
  logic [SLOT_W-1:0]   slot;
  logic [TIME_W-1:0]   key_time;
  logic [COLOR_W-1:0]  key_color;
  logic [COUNT_W-1:0]  key_count;
  logic [TIME_W-1:0]   query_time;

  modport source (output valid, opcode, band, slot, key_time, key_color, key_count,
                  query_time, input ready);
  modport sink   (input valid, opcode, band, slot, key_time, key_color, key_count,
                  query_time, output ready);
endinterface

>>> design/kci_out_if.sv
// output channel: interpolated color results
interface kci_out_if import kci_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic              band_empty;

  modport source (output valid, red, green, blue, band_empty, input ready);
  modport sink   (input valid, red, green, blue, band_empty, output ready);
endinterface

>>> design/keyframe_color_interpolator_top.sv
// keyframe and count writes are taken in S_IDLE; a query of an empty band goes straight to S_PUSH
// a query of a band with n keyframes reads the band's keyframes from keyframe memory,
// then runs 3 channels of 2 multiply and 8 divide steps
// on one shared multiplier and one shared restoring divider
// one item at a time; ready returns when the result sits in the output register
// reset clears the sequencer and all band counts at once; keyframe memory is not cleared
module keyframe_color_interpolator_top import kci_pkg::*; #(
  parameter int BANDS = BANDS_DEF,
  parameter int KEYS  = KEYS_DEF
) (
  input logic      clk_i,
  input logic      rst_ni,
  kci_in_if.sink   in_i,
  kci_out_if.source out_o
);

  localparam int DEPTH = BANDS * KEYS;
  localparam int AW    = $clog2(DEPTH);
  localparam int BW    = (BANDS > 1) ? $clog2(BANDS) : 1;
  localparam int CW    = $clog2(KEYS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_SEL  = 3'd2;
  localparam logic [2:0] S_SPAN = 3'd3;
  localparam logic [2:0] S_MULA = 3'd4;
  localparam logic [2:0] S_MULB = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_PUSH = 3'd7;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  function automatic logic [CHAN_W-1:0] chan_sel(input logic [COLOR_W-1:0] c,
                                                 input logic [1:0] ch);
    logic [CHAN_W-1:0] v;
    case (ch)
      CH_RED:   v = c[23:16];
      CH_GREEN: v = c[15:8];
      default:  v = c[7:0];
    endcase
    return v;
  endfunction

  logic [2:0]         state_q, state_d;
  logic [CW-1:0]      cnt_q [BANDS];
  key_entry_t         mem_q [DEPTH];
  key_entry_t         rdata_q;

  logic [AW-1:0]      base_q;
  logic [CW-1:0]      last_q;
  logic [CW-1:0]      k_q;
  logic [TIME_W-1:0]  qt_q;
  key_entry_t         first_q, last_e_q, sel_q, next_q;
  logic               next_known_q, before_q, empty_q;
  logic [XTIME_W-1:0] t1_q, t2_q, tq_q;
  logic [COLOR_W-1:0] c1_q, c2_q;
  logic [SPAN_W-1:0]  span_q, d_q;
  logic [1:0]         ch_q;
  logic [2:0]         bit_q;
  logic [NUM_W-1:0]   acc_q, div_q;
  logic [CHAN_W-1:0]  quo_q;
  logic [CHAN_W-1:0]  res_r_q, res_g_q, res_b_q;
  logic               out_valid_q;
  logic [CHAN_W-1:0]  out_r_q, out_g_q, out_b_q;
  logic               out_empty_q;

  logic               in_xfer, band_ok, slot_ok;
  logic [BW-1:0]      band_idx;
  logic [AW-1:0]      base_in, waddr, raddr;
  logic [CW-1:0]      cnt_sel, cnt_sat;
  logic               mem_we, mem_re;
  logic [CW-1:0]      j_idx;
  logic [DIFF_W-1:0]  span_s, dd_s;
  logic [CHAN_W-1:0]  mul_a;
  logic [SPAN_W-1:0]  mul_b;
  logic [NUM_W-1:0]   prod;
  logic               ge;
  logic [CHAN_W-1:0]  quo_nx;

  // input side decode
  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign band_ok    = (int'(in_i.band) < BANDS);
  assign slot_ok    = (int'(in_i.slot) < KEYS);
  assign band_idx   = BW'(in_i.band);
  assign base_in    = AW'(AW'(band_idx) * AW'(KEYS));
  assign waddr      = base_in + AW'(in_i.slot);
  assign cnt_sel    = band_ok ? cnt_q[band_idx] : '0;
  assign cnt_sat    = (int'(in_i.key_count) > KEYS) ? CW'(KEYS) : CW'(in_i.key_count);

  assign mem_we = in_xfer && (in_i.opcode == OP_WRITE_KEY) && band_ok && slot_ok;
  assign mem_re = (state_q == S_SCAN) && (k_q <= last_q);
  assign raddr  = base_q + AW'(k_q);
  assign j_idx  = k_q - 1'b1;

  // keyframe memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= '{ktime: in_i.key_time, color: in_i.key_color};
    end
    if (mem_re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < BANDS; b++) begin
        cnt_q[b] <= '0;
      end
    end else if (in_xfer && (in_i.opcode == OP_SET_COUNT) && band_ok) begin
      cnt_q[band_idx] <= cnt_sat;
    end
  end

  // span and offset, signed so a reversed segment shows up as negative
  assign span_s = $signed({1'b0, t2_q}) - $signed({1'b0, t1_q});
  assign dd_s   = $signed({1'b0, tq_q}) - $signed({1'b0, t1_q});

  // shared multiplier
  always_comb begin
    if (state_q == S_MULA) begin
      mul_a = chan_sel(c1_q, ch_q);
      mul_b = span_q - d_q;
    end else begin
      mul_a = chan_sel(c2_q, ch_q);
      mul_b = d_q;
    end
  end
  assign prod = NUM_W'(mul_a) * NUM_W'(mul_b);

  // shared restoring divider step
  assign ge     = (acc_q >= div_q);
  assign quo_nx = {quo_q[CHAN_W-2:0], ge};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer && (in_i.opcode == OP_QUERY)) begin
          state_d = (cnt_sel == '0) ? S_PUSH : S_SCAN;
        end
      end
      S_SCAN: begin
        if ((k_q != '0) && (j_idx == last_q)) begin
          state_d = S_SEL;
        end
      end
      S_SEL:  state_d = S_SPAN;
      S_SPAN: state_d = S_MULA;
      S_MULA: state_d = S_MULB;
      S_MULB: state_d = S_DIV;
      S_DIV: begin
        if (bit_q == '0) begin
          state_d = (ch_q == CH_BLUE) ? S_PUSH : S_MULA;
        end
      end
      S_PUSH: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == S_PUSH) && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_xfer && (in_i.opcode == OP_QUERY)) begin
          empty_q <= (cnt_sel == '0);
          res_r_q <= '0;
          res_g_q <= '0;
          res_b_q <= '0;
          base_q  <= base_in;
          last_q  <= cnt_sel - 1'b1;
          k_q     <= '0;
          qt_q    <= in_i.query_time;
        end
      end
      S_SCAN: begin
        k_q <= k_q + 1'b1;
        if (k_q != '0) begin
          // keep the last entry at or before the query time and the one after it
          if (j_idx == '0) begin
            first_q      <= rdata_q;
            before_q     <= (qt_q < rdata_q.ktime);
            sel_q        <= rdata_q;
            next_known_q <= 1'b0;
          end else if (rdata_q.ktime <= qt_q) begin
            sel_q        <= rdata_q;
            next_known_q <= 1'b0;
          end else if (!next_known_q) begin
            next_q       <= rdata_q;
            next_known_q <= 1'b1;
          end
          if (j_idx == last_q) begin
            last_e_q <= rdata_q;
          end
        end
      end
      S_SEL: begin
        if (before_q) begin
          c1_q <= last_e_q.color;
          t1_q <= XTIME_W'(last_e_q.ktime);
          c2_q <= first_q.color;
          t2_q <= XTIME_W'(first_q.ktime) + XTIME_W'(DAY_TICKS);
          tq_q <= XTIME_W'(qt_q) + XTIME_W'(DAY_TICKS);
        end else begin
          c1_q <= sel_q.color;
          t1_q <= XTIME_W'(sel_q.ktime);
          tq_q <= XTIME_W'(qt_q);
          if (next_known_q) begin
            c2_q <= next_q.color;
            t2_q <= XTIME_W'(next_q.ktime);
          end else begin
            c2_q <= first_q.color;
            t2_q <= XTIME_W'(first_q.ktime) + XTIME_W'(DAY_TICKS);
          end
        end
      end
      S_SPAN: begin
        ch_q <= CH_RED;
        if ($signed(span_s) <= 0) begin
          span_q <= SPAN_W'(1);
          d_q    <= '0;
        end else begin
          span_q <= span_s[SPAN_W-1:0];
          if ($signed(dd_s) < 0) begin
            d_q <= '0;
          end else if ($signed(dd_s) > $signed(span_s)) begin
            d_q <= span_s[SPAN_W-1:0];
          end else begin
            d_q <= dd_s[SPAN_W-1:0];
          end
        end
      end
      S_MULA: begin
        acc_q <= prod;
      end
      S_MULB: begin
        acc_q <= acc_q + prod;
        div_q <= NUM_W'(span_q) << (CHAN_W - 1);
        bit_q <= 3'(CHAN_W - 1);
        quo_q <= '0;
      end
      S_DIV: begin
        if (ge) begin
          acc_q <= acc_q - div_q;
        end
        div_q <= div_q >> 1;
        quo_q <= quo_nx;
        bit_q <= bit_q - 1'b1;
        if (bit_q == '0) begin
          case (ch_q)
            CH_RED:   res_r_q <= quo_nx;
            CH_GREEN: res_g_q <= quo_nx;
            default:  res_b_q <= quo_nx;
          endcase
          ch_q <= ch_q + 1'b1;
        end
      end
      S_PUSH: begin
        if (!out_valid_q || out_o.ready) begin
          out_r_q     <= res_r_q;
          out_g_q     <= res_g_q;
          out_b_q     <= res_b_q;
          out_empty_q <= empty_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.red        = out_r_q;
  assign out_o.green      = out_g_q;
  assign out_o.blue       = out_b_q;
  assign out_o.band_empty = out_empty_q;

`ifndef SYNTHESIS
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (k_q <= CW'(last_q + 1'b1)))
    else $error("keyframe scan ran past the band's last keyframe");

  a_span_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MULA) |-> ((span_q != '0) && (d_q <= span_q)))
    else $error("zero divisor or offset beyond span");

  a_div_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (acc_q < {div_q[NUM_W-2:0], 1'b0}))
    else $error("quotient overflows a channel");

  a_empty_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (in_i.opcode == OP_QUERY) && !band_ok) |=>
      ((state_q == S_PUSH) && empty_q))
    else $error("query of a missing band did not go straight to output");
`endif

endmodule

>>> tb/sv/testbench.sv
// testbench for the keyframe color interpolator: directed and random items against a predictor
`timescale 1ns / 100ps

module testbench;
  import kci_pkg::*;

  localparam int N_BANDS      = BANDS_DEF;
  localparam int N_KEYS       = KEYS_DEF;
  localparam int TIME_MAX     = (1 << TIME_W) - 1;
  localparam int RANDOM_ITEMS = 1000;
  localparam int QUIET_LIMIT  = 2000;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [OPCODE_W-1:0] opcode;
    logic [BAND_W-1:0]   band;
    logic [SLOT_W-1:0]   slot;
    logic [TIME_W-1:0]   key_time;
    logic [COLOR_W-1:0]  key_color;
    logic [COUNT_W-1:0]  key_count;
    logic [TIME_W-1:0]   query_time;
  } kf_item_t;

  typedef struct {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              band_empty;
  } rgb_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  kci_in_if  kf_in ();
  kci_out_if kf_out ();

  keyframe_color_interpolator_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (kf_in),
    .out_o  (kf_out)
  );

  // predictor copy of the keyframe store
  logic [TIME_W-1:0]  key_time_mem  [N_BANDS*N_KEYS];
  logic [COLOR_W-1:0] key_color_mem [N_BANDS*N_KEYS];
  bit                 key_loaded    [N_BANDS*N_KEYS];
  int                 key_count_mem [N_BANDS];
  rgb_result_t        color_q [$];

  int error_count;
  int live_items;
  int quiet_cycles;
  int stall_left;
  bit idle_on;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (error_count < 200) $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic logic [CHAN_W-1:0] mix_channel(input int a, input int b, input int span,
                                                    input int d);
    int q;
    q = (a * (span - d) + b * d) / span;
    return q[CHAN_W-1:0];
  endfunction

  function automatic rgb_result_t predict_color(input logic [BAND_W-1:0] band,
                                                input logic [TIME_W-1:0] qtime);
    rgb_result_t r;
    int base, last, i, t, t1, t2, first_t, span, d;
    logic [COLOR_W-1:0] c1, c2;
    r.red = '0;
    r.green = '0;
    r.blue = '0;
    r.band_empty = 1'b1;
    if (int'(band) >= N_BANDS) return r;
    if (key_count_mem[band] == 0) return r;
    base    = int'(band) * N_KEYS;
    last    = key_count_mem[band] - 1;
    first_t = int'(key_time_mem[base]);
    t       = int'(qtime);
    if (t < first_t) begin
      // before the first keyframe: segment runs from the last one across midnight
      c1 = key_color_mem[base + last];
      c2 = key_color_mem[base];
      t1 = int'(key_time_mem[base + last]);
      t2 = first_t + DAY_TICKS;
      t  = t + DAY_TICKS;
    end else begin
      i = last;
      while (i > 0 && int'(key_time_mem[base + i]) > t) i--;
      c1 = key_color_mem[base + i];
      t1 = int'(key_time_mem[base + i]);
      if (i == last) begin
        c2 = key_color_mem[base];
        t2 = first_t + DAY_TICKS;
      end else begin
        c2 = key_color_mem[base + i + 1];
        t2 = int'(key_time_mem[base + i + 1]);
      end
    end
    span = t2 - t1;
    if (span <= 0) begin
      span = 1;
      d    = 0;
    end else begin
      d = t - t1;
      if (d < 0) d = 0;
      if (d > span) d = span;
    end
    r.red        = mix_channel(int'(c1[23:16]), int'(c2[23:16]), span, d);
    r.green      = mix_channel(int'(c1[15:8]), int'(c2[15:8]), span, d);
    r.blue       = mix_channel(int'(c1[7:0]), int'(c2[7:0]), span, d);
    r.band_empty = 1'b0;
    return r;
  endfunction

  function automatic void apply_item(input kf_item_t it);
    case (it.opcode)
      OP_WRITE_KEY: if (int'(it.band) < N_BANDS && int'(it.slot) < N_KEYS) begin
        key_time_mem[int'(it.band) * N_KEYS + int'(it.slot)]  = it.key_time;
        key_color_mem[int'(it.band) * N_KEYS + int'(it.slot)] = it.key_color;
        key_loaded[int'(it.band) * N_KEYS + int'(it.slot)]    = 1'b1;
      end
      OP_SET_COUNT: if (int'(it.band) < N_BANDS) begin
        key_count_mem[it.band] = (int'(it.key_count) > N_KEYS) ? N_KEYS : int'(it.key_count);
      end
      OP_QUERY: color_q.insert(color_q.size(), predict_color(it.band, it.query_time));
      default: ;
    endcase
  endfunction

  function automatic logic [COLOR_W-1:0] random_color();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return COLOR_W'($urandom);
    endcase
  endfunction

  // fields that the opcode does not use are left random
  function automatic kf_item_t random_item();
    kf_item_t it;
    it.opcode     = OPCODE_W'($urandom_range(0, 3));
    it.band       = BAND_W'($urandom);
    it.slot       = SLOT_W'($urandom);
    it.key_time   = TIME_W'($urandom);
    it.key_color  = COLOR_W'($urandom);
    it.key_count  = COUNT_W'($urandom);
    it.query_time = TIME_W'($urandom);
    return it;
  endfunction

  function automatic kf_item_t key_item(input int band, input int slot, input int ktime,
                                        input logic [COLOR_W-1:0] color);
    kf_item_t it;
    it           = random_item();
    it.opcode    = OP_WRITE_KEY;
    it.band      = BAND_W'(band);
    it.slot      = SLOT_W'(slot);
    it.key_time  = TIME_W'(ktime);
    it.key_color = color;
    return it;
  endfunction

  function automatic kf_item_t count_item(input int band, input int cnt);
    kf_item_t it;
    it           = random_item();
    it.opcode    = OP_SET_COUNT;
    it.band      = BAND_W'(band);
    it.key_count = COUNT_W'(cnt);
    return it;
  endfunction

  function automatic kf_item_t query_item(input int band, input int qtime);
    kf_item_t it;
    it            = random_item();
    it.opcode     = OP_QUERY;
    it.band       = BAND_W'(band);
    it.query_time = TIME_W'(qtime);
    return it;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(input kf_item_t it);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      kf_in.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    kf_in.valid      <= 1'b1;
    kf_in.opcode     <= it.opcode;
    kf_in.band       <= it.band;
    kf_in.slot       <= it.slot;
    kf_in.key_time   <= it.key_time;
    kf_in.key_color  <= it.key_color;
    kf_in.key_count  <= it.key_count;
    kf_in.query_time <= it.query_time;
    @(posedge clk_i);
    while (!kf_in.ready) @(posedge clk_i);
    apply_item(it);
    if (it.opcode == OP_QUERY || (it.opcode != OP_UNUSED && int'(it.band) < N_BANDS))
      live_items++;
    @(negedge clk_i);
  endtask

  // a band whose count covers a never written slot gets that slot loaded instead of a query
  task automatic send_query(input int band, input int qtime);
    int s;
    s = -1;
    if (band < N_BANDS) begin
      for (int k = key_count_mem[band] - 1; k >= 0; k--)
        if (!key_loaded[band * N_KEYS + k]) s = k;
    end
    if (s < 0) send_item(query_item(band, qtime));
    else send_item(key_item(band, s, $urandom_range(0, DAY_TICKS - 1), random_color()));
  endtask

  task automatic test_empty_and_ignored();
    kf_item_t it;
    send_item(query_item(0, 0));
    send_item(query_item(31, TIME_MAX));
    send_item(key_item(N_BANDS, 0, 100, '1));
    send_item(count_item(31, 31));
    it        = random_item();
    it.opcode = OP_UNUSED;
    send_item(it);
  endtask

  task automatic test_single_keyframe();
    send_item(key_item(1, 0, 1000, 24'hffffff));
    send_item(count_item(1, 1));
    send_item(query_item(1, 0));
    send_item(query_item(1, TIME_MAX));
  endtask

  task automatic test_two_keyframes();
    send_item(key_item(2, 0, 100, 24'hff0000));
    send_item(key_item(2, 1, 1440, 24'h00ff00));
    send_item(count_item(2, 2));
    send_item(query_item(2, 770));
    send_item(query_item(2, 50));
    send_item(query_item(2, DAY_TICKS - 1));
  endtask

  // key times past the end of the day give a negative span, then a clamped offset
  task automatic test_odd_key_times();
    send_item(key_item(3, 0, 0, 24'h123456));
    send_item(key_item(3, 1, 3000, 24'habcdef));
    send_item(count_item(3, 2));
    send_item(query_item(3, 3500));
    send_item(key_item(3, 0, 1000, 24'hffffff));
    send_item(key_item(3, 1, 3500, 24'h000000));
    send_item(query_item(3, 100));
    send_item(query_item(3, 3600));
  endtask

  task automatic run_band_session();
    int b, n, cnt, t;
    int key_times [$];
    b = $urandom_range(0, N_BANDS - 1);
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, N_KEYS) : $urandom_range(1, 5);
    for (int k = 0; k < n; k++)
      key_times.insert(key_times.size(), int'($urandom_range(0, DAY_TICKS - 1)));
    key_times.sort();
    if (n > 1 && $urandom_range(0, 5) == 0) key_times[1] = key_times[0];
    if ($urandom_range(0, 9) == 0) key_times.shuffle();
    for (int k = 0; k < n; k++) send_item(key_item(b, k, key_times[k], random_color()));
    // a full band also tries counts above the number of slots
    cnt = (n == N_KEYS) ? $urandom_range(N_KEYS, (1 << COUNT_W) - 1) : n;
    send_item(count_item(b, cnt));
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 5))
        0: t = key_times[$urandom_range(0, n - 1)];
        1: t = key_times[$urandom_range(0, n - 1)] + (($urandom_range(0, 1) != 0) ? 1 : -1);
        2: t = ($urandom_range(0, 1) != 0) ? 0 : DAY_TICKS - 1;
        3: t = $urandom_range(DAY_TICKS, TIME_MAX);
        default: t = $urandom_range(0, DAY_TICKS - 1);
      endcase
      if (t < 0) t = 0;
      send_query(b, t);
    end
  endtask

  task automatic test_random_traffic();
    int start_items;
    kf_item_t it;
    start_items = live_items;
    while (live_items - start_items < RANDOM_ITEMS) begin
      if (live_items - start_items > RANDOM_ITEMS * 85 / 100) idle_on = 1'b0;
      if ($urandom_range(0, 3) != 0) begin
        run_band_session();
      end else begin
        repeat ($urandom_range(1, 4)) begin
          it = random_item();
          if (it.opcode == OP_QUERY) send_query(int'(it.band), int'(it.query_time));
          else send_item(it);
        end
      end
    end
  endtask

  always @(posedge clk_i) begin : check_colors
    rgb_result_t want;
    if (rst_ni && kf_out.valid && kf_out.ready) begin
      if (color_q.size() == 0) begin
        report_mismatch("color result with no query waiting");
      end else begin
        want = color_q.pop_front();
        if (kf_out.red !== want.red)
          report_mismatch($sformatf("red %0d, expected %0d", kf_out.red, want.red));
        if (kf_out.green !== want.green)
          report_mismatch($sformatf("green %0d, expected %0d", kf_out.green, want.green));
        if (kf_out.blue !== want.blue)
          report_mismatch($sformatf("blue %0d, expected %0d", kf_out.blue, want.blue));
        if (kf_out.band_empty !== want.band_empty)
          report_mismatch($sformatf("band_empty %0b, expected %0b", kf_out.band_empty,
                                    want.band_empty));
      end
    end
  end

  // result side stalls in bursts
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      kf_out.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      kf_out.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 12);
    end else begin
      kf_out.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((kf_in.valid && kf_in.ready) || (kf_out.valid && kf_out.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    kf_in.valid      = 1'b0;
    kf_in.opcode     = '0;
    kf_in.band       = '0;
    kf_in.slot       = '0;
    kf_in.key_time   = '0;
    kf_in.key_color  = '0;
    kf_in.key_count  = '0;
    kf_in.query_time = '0;
    kf_out.ready     = 1'b0;
    idle_on          = 1'b1;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    test_empty_and_ignored();
    test_single_keyframe();
    test_two_keyframes();
    test_odd_key_times();
    test_random_traffic();
    kf_in.valid <= 1'b0;
    while (color_q.size() != 0) @(posedge clk_i);
    // room for a stray result after the last expected one
    repeat (N_KEYS + 40) @(posedge clk_i);
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
